@@ hw/rtl/icaf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package icaf_pkg;

   // Fixed formats
   localparam int ANGLE_FRAC_BITS      = 16;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int WORK_SHIFT           = 20;
   localparam int TABLE_FRAC           = 24;

   localparam int XW     = 40;  // CORDIC x / y width
   localparam int ZW     = 36;  // CORDIC angle width, 2^-24 degrees
   localparam int MA_W   = 34;  // multiplier operand a
   localparam int MB_W   = 26;  // multiplier operand b
   localparam int P_W    = MA_W + MB_W;
   localparam int ACC_W  = 64;
   localparam int INC_W  = 50;  // angle increment width
   localparam int R_W    = 33;  // scaled rate width
   localparam int TAB_W  = 30;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [23:0]          INV_GAIN_Q24 = 24'd10188014;
   localparam logic signed [ZW-1:0] HALF_TURN    = 36'sd3019898880;

   localparam logic [15:0] BLEND_RESET     = 16'd64225;
   localparam logic [15:0] SMOOTHING_RESET = 16'd32768;
   localparam logic [14:0] DEADBAND_RESET  = 15'd5;
   localparam logic [15:0] GAIN_RESET      = 16'd10218;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BLEND     = 2'd0,
      REG_SMOOTHING = 2'd1,
      REG_DEADBAND  = 2'd2,
      REG_GAIN      = 2'd3
   } csr_index_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_SMA  = 4'd0,   // w * g
      OP_SMB  = 4'd1,   // (1 - w) * s, write smoothed rate
      OP_RG   = 4'd2,   // s * gain
      OP_DT   = 4'd3,   // r * dt, write increment
      OP_CLP  = 4'd4,   // load CORDIC for pitch
      OP_TKP  = 4'd5,   // take pitch angle and magnitude
      OP_MGL  = 4'd6,   // magnitude low part times inverse gain
      OP_MGH  = 4'd7,   // magnitude high part, write magnitude
      OP_CLR  = 4'd8,   // load CORDIC for roll
      OP_TKR  = 4'd9,   // take roll angle
      OP_PRED = 4'd10,  // prediction from gyro increment
      OP_BLA  = 4'd11,  // a * prediction
      OP_BLB  = 4'd12,  // (1 - a) * accel angle, write angle
      OP_YAW  = 4'd13   // integrate yaw
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
   } instr_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
      logic       load;
      logic       mul_en;
      logic       wb_en;
      logic       step_en;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
   } status_type;

   localparam int          PROG_W    = 5;
   localparam logic [4:0]  PROG_LAST = 5'd24;

   // Operation sequence for one sample
   function automatic instr_type prog_op(input logic [PROG_W-1:0] pc);
      instr_type ins;
      ins.axis = 2'd0;
      ins.op   = OP_YAW;
      case (pc)
         5'd0:    begin ins.op = OP_SMA;  ins.axis = 2'd0; end
         5'd1:    begin ins.op = OP_SMB;  ins.axis = 2'd0; end
         5'd2:    begin ins.op = OP_RG;   ins.axis = 2'd0; end
         5'd3:    begin ins.op = OP_DT;   ins.axis = 2'd0; end
         5'd4:    begin ins.op = OP_SMA;  ins.axis = 2'd1; end
         5'd5:    begin ins.op = OP_SMB;  ins.axis = 2'd1; end
         5'd6:    begin ins.op = OP_RG;   ins.axis = 2'd1; end
         5'd7:    begin ins.op = OP_DT;   ins.axis = 2'd1; end
         5'd8:    begin ins.op = OP_SMA;  ins.axis = 2'd2; end
         5'd9:    begin ins.op = OP_SMB;  ins.axis = 2'd2; end
         5'd10:   begin ins.op = OP_RG;   ins.axis = 2'd2; end
         5'd11:   begin ins.op = OP_DT;   ins.axis = 2'd2; end
         5'd12:   ins.op = OP_CLP;
         5'd13:   ins.op = OP_TKP;
         5'd14:   ins.op = OP_MGL;
         5'd15:   ins.op = OP_MGH;
         5'd16:   ins.op = OP_CLR;
         5'd17:   ins.op = OP_TKR;
         5'd18:   begin ins.op = OP_PRED; ins.axis = 2'd0; end
         5'd19:   begin ins.op = OP_BLA;  ins.axis = 2'd0; end
         5'd20:   begin ins.op = OP_BLB;  ins.axis = 2'd0; end
         5'd21:   begin ins.op = OP_PRED; ins.axis = 2'd1; end
         5'd22:   begin ins.op = OP_BLA;  ins.axis = 2'd1; end
         5'd23:   begin ins.op = OP_BLB;  ins.axis = 2'd1; end
         default: begin ins.op = OP_YAW;  ins.axis = 2'd2; end
      endcase
      return ins;
   endfunction

   function automatic logic is_mul(input op_type op);
      logic m;
      case (op)
         OP_SMA, OP_SMB, OP_RG, OP_DT, OP_MGL, OP_MGH, OP_BLA, OP_BLB: m = 1'b1;
         default: m = 1'b0;
      endcase
      return m;
   endfunction

   // Arctangent of 2^-i in 2^-24 degrees
   function automatic logic [TAB_W-1:0] atan_entry(input logic [4:0] i);
      logic [TAB_W-1:0] t;
      case (i)
         5'd0:  t = 30'd754974720;
         5'd1:  t = 30'd445687602;
         5'd2:  t = 30'd235489088;
         5'd3:  t = 30'd119537938;
         5'd4:  t = 30'd60000934;
         5'd5:  t = 30'd30029717;
         5'd6:  t = 30'd15018523;
         5'd7:  t = 30'd7509720;
         5'd8:  t = 30'd3754917;
         5'd9:  t = 30'd1877466;
         5'd10: t = 30'd938734;
         5'd11: t = 30'd469367;
         5'd12: t = 30'd234684;
         5'd13: t = 30'd117342;
         5'd14: t = 30'd58671;
         5'd15: t = 30'd29335;
         5'd16: t = 30'd14668;
         5'd17: t = 30'd7334;
         5'd18: t = 30'd3667;
         5'd19: t = 30'd1833;
         5'd20: t = 30'd917;
         5'd21: t = 30'd458;
         5'd22: t = 30'd229;
         5'd23: t = 30'd115;
         5'd24: t = 30'd57;
         5'd25: t = 30'd29;
         5'd26: t = 30'd14;
         5'd27: t = 30'd7;
         5'd28: t = 30'd4;
         5'd29: t = 30'd2;
         5'd30: t = 30'd1;
         default: t = 30'd0;
      endcase
      return t;
   endfunction

   // Clamp to the 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/icaf_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface icaf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic        [23:0] sample_time;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   sample_time, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   sample_time, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/icaf_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface icaf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pitch_deg;
   logic signed [31:0] roll_deg;
   logic signed [31:0] yaw_deg;

   modport source (output valid, pitch_deg, roll_deg, yaw_deg, input ready);
   modport sink   (input valid, pitch_deg, roll_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/icaf_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
module icaf_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output icaf_pkg::cmd_type         cmd,
   input  wire icaf_pkg::status_type status
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ISSUE = 5'b00010,
      S_WB    = 5'b00100,
      S_CORD  = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [icaf_pkg::PROG_W-1:0]   pc_ff, pc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   icaf_pkg::instr_type           instr, next_instr;
   logic [icaf_pkg::PROG_W-1:0]   pc_next;

   assign instr      = icaf_pkg::prog_op(pc_ff);
   assign pc_next    = pc_ff + 5'd1;
   assign next_instr = icaf_pkg::prog_op(pc_next);

   // Sequence operations
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.op       = instr.op;
      cmd.axis     = instr.axis;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               pc_in    = '0;
               state_in = icaf_pkg::is_mul(icaf_pkg::prog_op('0).op) ? S_ISSUE : S_WB;
            end
         end
         S_ISSUE: begin
            cmd.mul_en = 1'b1;
            state_in   = S_WB;
         end
         S_WB: begin
            cmd.wb_en = 1'b1;
            if (instr.op == icaf_pkg::OP_CLP || instr.op == icaf_pkg::OP_CLR) begin
               state_in = S_CORD;
            end else if (pc_ff == icaf_pkg::PROG_LAST) begin
               state_in = S_FIN;
            end else begin
               pc_in    = pc_next;
               state_in = icaf_pkg::is_mul(next_instr.op) ? S_ISSUE : S_WB;
            end
         end
         S_CORD: begin
            if (!status.cordic_done) begin
               cmd.step_en = 1'b1;
            end else begin
               pc_in    = pc_next;
               state_in = icaf_pkg::is_mul(next_instr.op) ? S_ISSUE : S_WB;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result until the transaction completes
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/icaf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module icaf_datapath #(
   parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire icaf_pkg::cmd_type                     cmd,
   output icaf_pkg::status_type                       status,
   input  wire logic                                  csr_wr_en,
   input  wire logic [icaf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [icaf_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  wire logic signed [15:0]                    accel_x,
   input  wire logic signed [15:0]                    accel_y,
   input  wire logic signed [15:0]                    accel_z,
   input  wire logic signed [15:0]                    gyro_x,
   input  wire logic signed [15:0]                    gyro_y,
   input  wire logic signed [15:0]                    gyro_z,
   input  wire logic [23:0]                           sample_time,
   output logic signed [31:0]                         pitch_deg,
   output logic signed [31:0]                         roll_deg,
   output logic signed [31:0]                         yaw_deg
);

   localparam int XW    = icaf_pkg::XW;
   localparam int ZW    = icaf_pkg::ZW;
   localparam int MA_W  = icaf_pkg::MA_W;
   localparam int MB_W  = icaf_pkg::MB_W;
   localparam int P_W   = icaf_pkg::P_W;
   localparam int ACC_W = icaf_pkg::ACC_W;
   localparam int INC_W = icaf_pkg::INC_W;
   localparam int R_W   = icaf_pkg::R_W;
   localparam int CW    = $clog2(CORDIC_STEPS + 1);
   localparam int INC_SH = 32 - icaf_pkg::ANGLE_FRAC_BITS;
   localparam int ANG_SH = icaf_pkg::TABLE_FRAC - icaf_pkg::ANGLE_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HALF16   = 64'sd32768;
   localparam logic signed [ACC_W-1:0] INC_BIAS = 64'sd1 <<< (INC_SH - 1);
   localparam logic signed [ACC_W-1:0] ANG_BIAS = (ANG_SH > 0) ? (64'sd1 <<< (ANG_SH - 1))
                                                               : 64'sd0;
   localparam logic signed [ACC_W-1:0] MAG_BIAS = 64'sd8388608;
   localparam logic [CW-1:0] STEPS_LAST = CW'(CORDIC_STEPS);

   // Configuration
   logic [15:0] blend_ff, smooth_ff, gain_ff;
   logic [14:0] deadband_ff;

   // Sample registers
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] g_ff [3];
   logic [23:0]        dt_ff;
   logic [23:0]        prev_time_ff;
   logic               first_ff;

   // Filter state
   logic signed [31:0]    s_ff [3];
   logic signed [INC_W-1:0] inc_ff [3];
   logic signed [31:0]    pitch_ff, roll_ff, yaw_ff;
   logic signed [R_W-1:0] r_ff;
   logic signed [31:0]    pred_ff;
   logic signed [31:0]    ang_p_ff, ang_r_ff;
   logic signed [XW-1:0]  magx_ff, mag_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [P_W-1:0] prod_ff;
   logic signed [31:0]    out_p_ff, out_r_ff, out_y_ff;

   // CORDIC
   logic signed [XW-1:0] cx_ff, cy_ff;
   logic signed [ZW-1:0] cz_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 zf_ff;

   // Deadband on the incoming gyro axes
   function automatic logic signed [15:0] deadband(input logic signed [15:0] g,
                                                   input logic [14:0] db);
      logic [16:0] mg;
      mg = g[15] ? (17'd0 - {g[15], g}) : {1'b0, g};
      return (mg < {2'b00, db}) ? 16'sd0 : g;
   endfunction

   // Multiplier operand selection
   logic signed [MA_W-1:0] ma;
   logic signed [MB_W-1:0] mb;
   logic [16:0]            w_inv, a_inv;
   logic signed [31:0]     s_sel;
   logic signed [INC_W-1:0] inc_sel;

   assign w_inv   = 17'h10000 - {1'b0, smooth_ff};
   assign a_inv   = 17'h10000 - {1'b0, blend_ff};
   assign s_sel   = s_ff[cmd.axis];
   assign inc_sel = inc_ff[cmd.axis];

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         icaf_pkg::OP_SMA: begin
            ma = MA_W'(g_ff[cmd.axis]);
            mb = $signed({10'd0, smooth_ff});
         end
         icaf_pkg::OP_SMB: begin
            ma = MA_W'(s_sel);
            mb = $signed({9'd0, w_inv});
         end
         icaf_pkg::OP_RG: begin
            ma = MA_W'(s_sel);
            mb = $signed({10'd0, gain_ff});
         end
         icaf_pkg::OP_DT: begin
            ma = MA_W'(r_ff);
            mb = $signed({2'd0, dt_ff});
         end
         icaf_pkg::OP_MGL: begin
            ma = $signed({14'd0, magx_ff[19:0]});
            mb = $signed({2'd0, icaf_pkg::INV_GAIN_Q24});
         end
         icaf_pkg::OP_MGH: begin
            ma = MA_W'(magx_ff >>> icaf_pkg::WORK_SHIFT);
            mb = $signed({2'd0, icaf_pkg::INV_GAIN_Q24});
         end
         icaf_pkg::OP_BLA: begin
            ma = MA_W'(pred_ff);
            mb = $signed({10'd0, blend_ff});
         end
         icaf_pkg::OP_BLB: begin
            ma = (cmd.axis == 2'd0) ? MA_W'(ang_p_ff) : MA_W'(ang_r_ff);
            mb = $signed({9'd0, a_inv});
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // Writeback arithmetic
   logic signed [ACC_W-1:0] prod_x, sum16, ang_z;
   logic signed [31:0]      rounded16, ang_sat;

   assign prod_x    = ACC_W'(prod_ff);
   assign sum16     = (acc_ff + prod_x + HALF16) >>> 16;
   assign rounded16 = icaf_pkg::sat32(sum16);
   assign ang_z     = (ACC_W'(cz_ff) + ANG_BIAS) >>> ANG_SH;
   assign ang_sat   = zf_ff ? 32'sd0 : icaf_pkg::sat32(ang_z);

   // CORDIC load values
   logic signed [XW-1:0] x0, y0;
   assign x0 = (cmd.op == icaf_pkg::OP_CLP) ? (XW'(az_ff) <<< icaf_pkg::WORK_SHIFT) : mag_ff;
   assign y0 = (cmd.op == icaf_pkg::OP_CLP) ? (XW'(ay_ff) <<< icaf_pkg::WORK_SHIFT)
                                            : -(XW'(ax_ff) <<< icaf_pkg::WORK_SHIFT);

   // CORDIC step
   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] tab_z;
   logic                 y_pos;
   assign xs    = cx_ff >>> cnt_ff;
   assign ys    = cy_ff >>> cnt_ff;
   assign tab_z = $signed({{(ZW - icaf_pkg::TAB_W){1'b0}}, icaf_pkg::atan_entry(5'(cnt_ff))});
   assign y_pos = !cy_ff[XW-1] && (cy_ff != '0);

   assign status.cordic_done = (cnt_ff == STEPS_LAST);

   // Configuration and control-like state
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff     <= icaf_pkg::BLEND_RESET;
         smooth_ff    <= icaf_pkg::SMOOTHING_RESET;
         deadband_ff  <= icaf_pkg::DEADBAND_RESET;
         gain_ff      <= icaf_pkg::GAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (icaf_pkg::csr_index_type'(csr_index))
            icaf_pkg::REG_BLEND:     blend_ff    <= csr_wr_data;
            icaf_pkg::REG_SMOOTHING: smooth_ff   <= csr_wr_data;
            icaf_pkg::REG_DEADBAND:  deadband_ff <= csr_wr_data[14:0];
            icaf_pkg::REG_GAIN:      gain_ff     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Filter state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         first_ff     <= 1'b1;
         s_ff[0]      <= '0;
         s_ff[1]      <= '0;
         s_ff[2]      <= '0;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         yaw_ff       <= '0;
         cnt_ff       <= STEPS_LAST;
      end else begin
         if (cmd.load) begin
            prev_time_ff <= sample_time;
            first_ff     <= 1'b0;
         end
         if (cmd.wb_en) begin
            case (cmd.op)
               icaf_pkg::OP_SMB: s_ff[cmd.axis] <= rounded16;
               icaf_pkg::OP_BLB: begin
                  if (cmd.axis == 2'd0) begin
                     pitch_ff <= rounded16;
                  end else begin
                     roll_ff <= rounded16;
                  end
               end
               icaf_pkg::OP_YAW: yaw_ff <= icaf_pkg::sat32(ACC_W'(yaw_ff) + ACC_W'(inc_sel));
               icaf_pkg::OP_CLP, icaf_pkg::OP_CLR: cnt_ff <= '0;
               default: ;
            endcase
         end
         if (cmd.step_en) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff   <= accel_x;
         ay_ff   <= accel_y;
         az_ff   <= accel_z;
         g_ff[0] <= deadband(gyro_x, deadband_ff);
         g_ff[1] <= deadband(gyro_y, deadband_ff);
         g_ff[2] <= deadband(gyro_z, deadband_ff);
         dt_ff   <= first_ff ? 24'd0 : (sample_time - prev_time_ff);
      end
      if (cmd.mul_en) begin
         prod_ff <= ma * mb;
      end
      if (cmd.wb_en) begin
         case (cmd.op)
            icaf_pkg::OP_SMA: acc_ff <= prod_x <<< 16;
            icaf_pkg::OP_RG:  r_ff   <= R_W'((prod_x + HALF16) >>> 16);
            icaf_pkg::OP_DT:  inc_ff[cmd.axis] <= INC_W'((prod_x + INC_BIAS) >>> INC_SH);
            icaf_pkg::OP_MGL: acc_ff <= prod_x + MAG_BIAS;
            icaf_pkg::OP_MGH: mag_ff <= XW'((prod_x + (acc_ff >>> 20)) >>> 4);
            icaf_pkg::OP_BLA: acc_ff <= prod_x;
            icaf_pkg::OP_PRED: begin
               pred_ff <= icaf_pkg::sat32((cmd.axis == 2'd0 ? ACC_W'(pitch_ff) : ACC_W'(roll_ff))
                                          + ACC_W'(inc_sel));
            end
            icaf_pkg::OP_CLP, icaf_pkg::OP_CLR: begin
               zf_ff <= (x0 == '0) && (y0 == '0);
               if (x0[XW-1]) begin
                  cx_ff <= -x0;
                  cy_ff <= -y0;
                  cz_ff <= y0[XW-1] ? -icaf_pkg::HALF_TURN : icaf_pkg::HALF_TURN;
               end else begin
                  cx_ff <= x0;
                  cy_ff <= y0;
                  cz_ff <= '0;
               end
            end
            icaf_pkg::OP_TKP: begin
               ang_p_ff <= ang_sat;
               magx_ff  <= zf_ff ? '0 : cx_ff;
            end
            icaf_pkg::OP_TKR: ang_r_ff <= ang_sat;
            default: ;
         endcase
      end
      // Rotate toward the x axis
      if (cmd.step_en) begin
         if (y_pos) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + tab_z;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - tab_z;
         end
      end
      if (cmd.out_load) begin
         out_p_ff <= pitch_ff;
         out_r_ff <= roll_ff;
         out_y_ff <= yaw_ff;
      end
   end

   assign pitch_deg = out_p_ff;
   assign roll_deg  = out_r_ff;
   assign yaw_deg   = out_y_ff;

endmodule
`default_nettype wire

@@ hw/rtl/imu_complementary_attitude_filter_top.sv @@
// Attitude filter for a six-axis IMU. Each req_chan transaction carries three accelerometer
// axes, three gyro axes and a 24-bit timestamp; each rsp_chan transaction returns pitch,
// roll and yaw as saturating signed Q16.16 degrees. One sample is processed at a time:
// sample passes through the shared 34x26 multiplier (18 products), seven steps without a
// product and the two passes of the one-step-per-cycle vectoring CORDIC for pitch and roll,
// between the accept and the result load. A new sample is taken while the previous result
// still waits on rsp_chan; the result load of that new sample then stalls until the waiting
// result is taken. The first sample after reset sees zero elapsed time. Configuration writes
// on the csr_ port belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none
module imu_complementary_attitude_filter_top #(
   parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   icaf_req_if.sink                               req_chan,
   icaf_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [icaf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [icaf_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   icaf_pkg::cmd_type    cmd;
   icaf_pkg::status_type status;

   // Sequence control
   icaf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and state
   icaf_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .accel_x     (req_chan.accel_x),
      .accel_y     (req_chan.accel_y),
      .accel_z     (req_chan.accel_z),
      .gyro_x      (req_chan.gyro_x),
      .gyro_y      (req_chan.gyro_y),
      .gyro_z      (req_chan.gyro_z),
      .sample_time (req_chan.sample_time),
      .pitch_deg   (rsp_chan.pitch_deg),
      .roll_deg    (rsp_chan.roll_deg),
      .yaw_deg     (rsp_chan.yaw_deg)
   );

endmodule
`default_nettype wire

@@ hw/rtl/icaf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module icaf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_yaw_deg
);

   // Result pending holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transaction");

   // Payload stays put while stalled
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_yaw_deg))
      else $error("result changed while stalled");

   // One sample in flight: no back-to-back accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample accepted while busy");

   // Reset clears the result channel
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind imu_complementary_attitude_filter_top icaf_checker u_icaf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_yaw_deg (rsp_chan.yaw_deg)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;

   typedef struct {
      logic signed [15:0] ax, ay, az;
      logic signed [15:0] gx, gy, gz;
      logic        [23:0] stamp;
   } imu_sample_type;

   typedef struct {
      logic signed [31:0] pitch, roll, yaw;
   } attitude_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [icaf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [icaf_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   icaf_req_if req_chan ();
   icaf_rsp_if rsp_chan ();

   imu_complementary_attitude_filter_top dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      req_chan.valid = 1'b0;
      req_chan.accel_x = '0; req_chan.accel_y = '0; req_chan.accel_z = '0;
      req_chan.gyro_x = '0;  req_chan.gyro_y = '0;  req_chan.gyro_z = '0;
      req_chan.sample_time = '0;
      rsp_chan.ready = 1'b0;
   end

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   imu_sample_type sample_q[$];
   attitude_type   attitude_q[$];
   int          n_errors = 0;
   int          n_in = 0;
   int          n_out = 0;
   longint      cycle_cnt = 0;
   logic        req_taken = 1'b0;

   // Predictor copy of registers and filter state
   longint blend_w, smooth_w, deadband, gain;
   longint pitch_st, roll_st, yaw_st;
   longint rate_st[3];
   logic [23:0] last_stamp;
   logic        first_pending;

   longint atan_tab[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                            30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                            469367, 234684, 117342, 58671, 29335};

   function automatic longint rnd(input longint v, input int n);
      if (n == 0) return v;
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Vectoring rotation: angle in 2^-24 degrees, gain-scaled magnitude out
   function automatic longint vector_angle(input longint x0, input longint y0,
                                           output longint mag);
      longint x, y, z, xs, ys;
      x = x0; y = y0; z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? (longint'(180) <<< 24) : -(longint'(180) <<< 24);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_tab[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_tab[i];
         end
      end
      mag = x;
      return z;
   endfunction

   // Advance the filter state by one sample and return the new angles
   function automatic attitude_type filter_step(input imu_sample_type s);
      attitude_type res;
      longint dt, g, r, mag, unused, pa, ra, pred;
      longint inc[3];
      longint gyro[3];
      gyro[0] = s.gx; gyro[1] = s.gy; gyro[2] = s.gz;
      if (first_pending) begin
         dt = 0;
         first_pending = 1'b0;
      end else begin
         dt = longint'(24'(s.stamp - last_stamp));
      end
      last_stamp = s.stamp;
      for (int k = 0; k < 3; k++) begin
         g = gyro[k];
         if ((g < 0 ? -g : g) < deadband) g = 0;
         rate_st[k] = clamp32(rnd(smooth_w * g * 65536 + (65536 - smooth_w) * rate_st[k], 16));
         r = rnd(rate_st[k] * gain, 16);
         inc[k] = rnd(r * dt, 32 - icaf_pkg::ANGLE_FRAC_BITS);
      end
      pa = vector_angle(longint'(s.az) <<< 20, longint'(s.ay) <<< 20, mag);
      mag = rnd(mag * 10188014, 24);
      ra = vector_angle(mag, -(longint'(s.ax) <<< 20), unused);
      pa = clamp32(rnd(pa, 24 - icaf_pkg::ANGLE_FRAC_BITS));
      ra = clamp32(rnd(ra, 24 - icaf_pkg::ANGLE_FRAC_BITS));
      pred = clamp32(pitch_st + inc[0]);
      pitch_st = clamp32(rnd(blend_w * pred + (65536 - blend_w) * pa, 16));
      pred = clamp32(roll_st + inc[1]);
      roll_st = clamp32(rnd(blend_w * pred + (65536 - blend_w) * ra, 16));
      yaw_st = clamp32(yaw_st + inc[2]);
      res.pitch = pitch_st[31:0];
      res.roll  = roll_st[31:0];
      res.yaw   = yaw_st[31:0];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      n_errors++;
      if (n_errors <= 20)
         $display("MISMATCH result %0d %s: got %0d expected %0d", n_out, field,
                  $signed(got), $signed(want));
   endtask

   // Monitor: predict on each accepted sample, check each accepted result
   always @(posedge clock) begin
      attitude_type want;
      cycle_cnt <= cycle_cnt + 1;
      req_taken <= req_chan.valid && req_chan.ready && !reset;
      if (!reset && req_chan.valid && req_chan.ready) begin
         imu_sample_type s;
         s.ax = req_chan.accel_x; s.ay = req_chan.accel_y; s.az = req_chan.accel_z;
         s.gx = req_chan.gyro_x;  s.gy = req_chan.gyro_y;  s.gz = req_chan.gyro_z;
         s.stamp = req_chan.sample_time;
         attitude_q.push_back(filter_step(s));
         n_in++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         n_out++;
         if (attitude_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 20) $display("MISMATCH unexpected result %0d", n_out);
         end else begin
            want = attitude_q.pop_front();
            if (rsp_chan.pitch_deg !== want.pitch)
               report_mismatch("pitch_deg", rsp_chan.pitch_deg, want.pitch);
            if (rsp_chan.roll_deg !== want.roll)
               report_mismatch("roll_deg", rsp_chan.roll_deg, want.roll);
            if (rsp_chan.yaw_deg !== want.yaw)
               report_mismatch("yaw_deg", rsp_chan.yaw_deg, want.yaw);
         end
      end
   end

   // Driver: offer queued samples in bursts separated by gaps
   int burst_left = 4;
   int gap_left = 0;
   always @(negedge clock) begin
      logic nv;
      imu_sample_type s;
      nv = req_chan.valid;
      if (!req_chan.valid || req_taken) begin
         nv = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (sample_q.size() > 0) begin
            s = sample_q.pop_front();
            nv = 1'b1;
            req_chan.accel_x <= s.ax; req_chan.accel_y <= s.ay; req_chan.accel_z <= s.az;
            req_chan.gyro_x <= s.gx;  req_chan.gyro_y <= s.gy;  req_chan.gyro_z <= s.gz;
            req_chan.sample_time <= s.stamp;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            end
         end
      end
      req_chan.valid <= nv;
   end

   // Receiver: stall pattern changes now and then; one long hold-off
   int hold_left = 0;
   logic hold_done = 1'b0;
   int mode = 0;
   int mode_left = 0;
   always @(negedge clock) begin
      logic nr;
      if (mode_left == 0) begin
         mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 400);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         nr = 1'b0;
      end else if (!hold_done && n_in >= 400) begin
         hold_done = 1'b1;
         hold_left = 3000;
         nr = 1'b0;
      end else begin
         case (mode)
            0: nr = 1'b1;
            1: nr = $urandom_range(0, 1);
            default: nr = ($urandom_range(0, 3) == 0);
         endcase
      end
      rsp_chan.ready <= nr;
   end

   // Run limit
   always @(posedge clock) begin
      if (cycle_cnt > 3000000) begin
         $display("imu_complementary_attitude_filter_top regression: fail");
         $finish;
      end
   end

   logic [23:0] stamp_next = 24'd0;

   function automatic logic signed [15:0] pick_gyro();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) return 16'($signed($urandom_range(0, 80)) - 40);
      if (sel == 3) return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      return 16'($urandom);
   endfunction

   function automatic logic signed [15:0] pick_accel();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 16'sd0;
      if (sel == 1) return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      if (sel < 4) return 16'($signed($urandom_range(0, 2000)) - 1000);
      return 16'($urandom);
   endfunction

   // Mostly steady timestamps; now and then a jump or a wrap backwards
   function automatic imu_sample_type random_sample();
      imu_sample_type s;
      int sel;
      s.ax = pick_accel(); s.ay = pick_accel(); s.az = pick_accel();
      s.gx = pick_gyro();  s.gy = pick_gyro();  s.gz = pick_gyro();
      sel = $urandom_range(0, 19);
      if (sel < 16) stamp_next = stamp_next + 24'($urandom_range(0, 3000));
      else if (sel < 18) stamp_next = 24'($urandom);
      else stamp_next = stamp_next - 24'($urandom_range(1, 1000));
      s.stamp = stamp_next;
      return s;
   endfunction

   function automatic imu_sample_type make_sample(input int ax, ay, az, gx, gy, gz,
                                                  input int stamp);
      imu_sample_type s;
      s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
      s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
      s.stamp = 24'(stamp);
      return s;
   endfunction

   task automatic write_reg(input icaf_pkg::csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = value;
      case (idx)
         icaf_pkg::REG_BLEND:     blend_w = value;
         icaf_pkg::REG_SMOOTHING: smooth_w = value;
         icaf_pkg::REG_DEADBAND:  deadband = value[14:0];
         default:                 gain = value;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Wait until every queued sample has been sent and its result checked
   task automatic drain();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_chan.valid || attitude_q.size() != 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_all(input logic [15:0] b, s, d, g);
      write_reg(icaf_pkg::REG_BLEND, b);
      write_reg(icaf_pkg::REG_SMOOTHING, s);
      write_reg(icaf_pkg::REG_DEADBAND, {1'b0, d[14:0]});
      write_reg(icaf_pkg::REG_GAIN, g);
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++) sample_q.push_back(random_sample());
   endtask

   initial begin
      blend_w = icaf_pkg::BLEND_RESET; smooth_w = icaf_pkg::SMOOTHING_RESET;
      deadband = icaf_pkg::DEADBAND_RESET; gain = icaf_pkg::GAIN_RESET;
      pitch_st = 0; roll_st = 0; yaw_st = 0;
      rate_st[0] = 0; rate_st[1] = 0; rate_st[2] = 0;
      last_stamp = '0;
      first_pending = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero vector on first sample, deadband edges, extremes, wrap
      sample_q.push_back(make_sample(0, 0, 0, 4, -4, 5, 1000));
      sample_q.push_back(make_sample(0, 0, 16384, 5, -5, -6, 1100));
      sample_q.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, 1200));
      sample_q.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 1300));
      sample_q.push_back(make_sample(0, 100, -16384, 0, 0, 0, 1400));
      sample_q.push_back(make_sample(0, -100, -16384, 0, 0, 0, 1500));
      sample_q.push_back(make_sample(16384, 0, -1, 0, 0, 0, 1600));
      sample_q.push_back(make_sample(-16384, 0, 0, 1, -1, 0, 1600));
      sample_q.push_back(make_sample(0, 0, 0, 30000, -30000, 30000, 1000));
      sample_q.push_back(make_sample(0, 0, 0, 30000, -30000, 30000, 16777215));
      sample_q.push_back(make_sample(100, -200, 300, 0, 0, 0, 0));
      drain();

      // Largest weights and gain: drive yaw and the angles into saturation
      write_all(16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF);
      sample_q.push_back(make_sample(0, 0, 0, -32768, 32767, -32768, 5000000));
      sample_q.push_back(make_sample(0, 0, 0, 32767, 32767, 32767, 5000010));
      drain();
      write_all(16'hFFFF, 16'hFFFF, 15'd0, 16'hFFFF);
      for (int i = 0; i < 6; i++)
         sample_q.push_back(make_sample(0, 0, 0, 32767, -32768, 32767, 6000000 + i * 4000000));
      for (int i = 0; i < 6; i++)
         sample_q.push_back(make_sample(0, 0, 0, -32768, 32767, -32768, 3000000 + i * 4000000));
      drain();

      // Smallest settings
      write_all(16'd0, 16'd0, 15'd0, 16'd0);
      queue_random(30);
      drain();

      // Reset values again, then the bulk of random phases
      write_all(icaf_pkg::BLEND_RESET, icaf_pkg::SMOOTHING_RESET, icaf_pkg::DEADBAND_RESET,
                icaf_pkg::GAIN_RESET);
      queue_random(500);
      drain();
      for (int p = 0; p < 6; p++) begin
         write_all(16'($urandom), 16'($urandom), 15'($urandom_range(0, 64)),
                   16'($urandom));
         queue_random(90);
         drain();
      end
      write_all(16'hFFFF, 16'd1, 15'h7FFF, 16'd1);
      queue_random(20);
      drain();

      $display("Covered %0d samples and %0d results under a dozen register settings,",
               n_in, n_out);
      $display("including saturation, timestamp wrap, deadband edges and a long output stall.");
      if (n_errors == 0 && attitude_q.size() == 0) begin
         $display("imu_complementary_attitude_filter_top regression: pass");
      end else begin
         $display("imu_complementary_attitude_filter_top regression: fail");
      end
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/icaf_pkg.sv
hw/rtl/icaf_req_if.sv
hw/rtl/icaf_rsp_if.sv
hw/rtl/icaf_controller.sv
hw/rtl/icaf_datapath.sv
hw/rtl/imu_complementary_attitude_filter_top.sv
hw/rtl/icaf_checker.sv
tb/sv/tb.sv
